/* sv/ckblit_pkg.sv */
// Shared types, codes and constants of the color-keyed sprite blitter.
package ckblit_pkg;

  // Item function codes
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Default sprite side limit (sides saturate to one below it)
  localparam int DEFAULT_MAX_SPRITE_SIDE = 4096;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Reset values of the configuration registers
  localparam logic [11:0] RESET_SCREEN_WIDTH  = 12'd1024;
  localparam logic [11:0] RESET_SCREEN_HEIGHT = 12'd768;
  localparam logic [2:0]  RESET_PIXEL_BYTES   = 3'd4;
  localparam logic [31:0] RESET_KEY_COLOR     = 32'd0;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_PIXEL_BYTES   = 2'd2,
    REG_KEY_COLOR     = 2'd3
  } cfg_reg_t;

  // Input item
  typedef struct packed {
    logic        func;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [11:0] sprite_width;
    logic [11:0] sprite_height;
    logic        erase_mode;
    logic [31:0] pixel_color;
  } item_t;

  // Result item
  typedef struct packed {
    logic        write_enable;
    logic [25:0] byte_address;
    logic [31:0] write_data;
    logic [2:0]  byte_count;
    logic        last;
  } result_t;

  // Classified pixel record handed from front to back
  typedef struct packed {
    logic        we;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] data;
    logic [2:0]  bytes;
    logic        last;
  } pixel_rec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* sv/color_keyed_sprite_blit_unit.sv */
// Top level of the color-keyed sprite blitter.
// A begin item sets the sprite origin, size and draw or erase mode; pixel items then
// follow in row-major order and each gives one result: a write enable (on screen and
// not equal to the key color), the frame buffer byte address (y*width+x)*bytes, the
// masked color (zero when erasing) with its byte count, and a mark on the last pixel.
// Begin items and pixels with no sprite active give no result. One item is taken per
// cycle while the queue is not full; the front part classifies it in the accepting
// cycle and a four-entry queue feeds the back part, which registers the pixel index and
// then the result. Sprite sides saturate at MAX_SPRITE_SIDE-1, at most 4095. The user
// must write configuration only while no item is in flight; it is not enforced here.
module color_keyed_sprite_blit_unit #(
  parameter int MAX_SPRITE_SIDE = ckblit_pkg::DEFAULT_MAX_SPRITE_SIDE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  ckblit_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output ckblit_pkg::result_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ckblit_pkg::*;

  logic          push;
  logic          pop;
  pixel_rec_t    push_rec;
  pixel_rec_t    head;
  queue_status_t q_status;
  logic [11:0]   stride;

  ckblit_front #(
    .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .push       (push),
    .rec        (push_rec),
    .stride     (stride)
  );

  ckblit_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  ckblit_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (head),
    .pop          (pop),
    .stride       (stride),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* sv/ckblit_front.sv */
// Front part: configuration registers, sprite tracking and pixel classification.
module ckblit_front #(
  parameter int MAX_SPRITE_SIDE = ckblit_pkg::DEFAULT_MAX_SPRITE_SIDE
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  ckblit_pkg::item_t      item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  ckblit_pkg::queue_status_t q_status,
  output logic                   push,
  output ckblit_pkg::pixel_rec_t rec,
  output logic [11:0]            stride
);
  import ckblit_pkg::*;

  localparam int SIDE_W   = (MAX_SPRITE_SIDE >= 4096) ? 12 : $clog2(MAX_SPRITE_SIDE);
  localparam int SIDE_LIM = (MAX_SPRITE_SIDE >= 4096) ? 4095 : MAX_SPRITE_SIDE - 1;
  localparam logic [11:0]       LIM_FIELD = 12'(SIDE_LIM);
  localparam logic [SIDE_W-1:0] LIM_SIDE  = SIDE_W'(SIDE_LIM);

  // Configuration registers
  logic [11:0] screen_width;
  logic [11:0] screen_height;
  logic [2:0]  pixel_bytes;
  logic [31:0] key_color;

  // Sprite state
  logic [15:0]       base_x;
  logic [15:0]       base_y;
  logic [SIDE_W-1:0] span_w;
  logic [SIDE_W-1:0] span_h;
  logic [SIDE_W-1:0] column;
  logic [SIDE_W-1:0] row;
  logic              erasing;
  logic              active;

  logic              accept;
  logic [SIDE_W-1:0] w_clamped;
  logic [SIDE_W-1:0] h_clamped;
  logic [15:0]       x;
  logic [15:0]       y;
  logic [SIDE_W:0]   col_inc;
  logic [SIDE_W:0]   row_inc;
  logic              is_last;
  logic              on_screen;
  logic              opaque;
  logic              we;
  logic [2:0]        bytes_eff;
  logic [31:0]       mask;
  cfg_reg_t          cfg_sel;

  assign cfg_ready  = 1'b1;
  assign item_stall = q_status.full;
  assign accept     = item_valid && !item_stall;
  assign stride     = screen_width;
  assign cfg_sel    = cfg_reg_t'(cfg_index);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_SCREEN_WIDTH;
      screen_height <= RESET_SCREEN_HEIGHT;
      pixel_bytes   <= RESET_PIXEL_BYTES;
      key_color     <= RESET_KEY_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_sel)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[11:0];
        REG_PIXEL_BYTES:   pixel_bytes   <= cfg_data[2:0];
        REG_KEY_COLOR:     key_color     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate sprite sides to the limit
  assign w_clamped = (item.sprite_width  > LIM_FIELD) ? LIM_SIDE : item.sprite_width[SIDE_W-1:0];
  assign h_clamped = (item.sprite_height > LIM_FIELD) ? LIM_SIDE : item.sprite_height[SIDE_W-1:0];

  // Screen coordinate, clipping and key test
  assign x         = base_x + 16'(column);
  assign y         = base_y + 16'(row);
  assign col_inc   = {1'b0, column} + 1'b1;
  assign row_inc   = {1'b0, row} + 1'b1;
  assign is_last   = (col_inc == {1'b0, span_w}) && (row_inc == {1'b0, span_h});
  assign on_screen = (x < 16'(screen_width)) && (y < 16'(screen_height));
  assign opaque    = item.pixel_color != key_color;
  assign we        = on_screen && opaque;

  // Effective bytes per pixel and data mask
  always_comb begin
    case (pixel_bytes) inside
      3'd0:                   bytes_eff = 3'd1;
      3'd1, 3'd2, 3'd3, 3'd4: bytes_eff = pixel_bytes;
      default:                bytes_eff = 3'd4;
    endcase
    case (bytes_eff)
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  // Record for the back part
  assign push     = accept && (item.func == FUNC_PIXEL) && active;
  assign rec.we    = we;
  assign rec.x     = we ? x[11:0] : 12'd0;
  assign rec.y     = we ? y[11:0] : 12'd0;
  assign rec.data  = (we && !erasing) ? (item.pixel_color & mask) : 32'd0;
  assign rec.bytes = bytes_eff;
  assign rec.last  = is_last;

  // Sprite tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      base_x  <= '0;
      base_y  <= '0;
      span_w  <= '0;
      span_h  <= '0;
      column  <= '0;
      row     <= '0;
      erasing <= 1'b0;
      active  <= 1'b0;
    end else if (accept && item.func == FUNC_BEGIN) begin
      base_x  <= item.origin_x;
      base_y  <= item.origin_y;
      span_w  <= w_clamped;
      span_h  <= h_clamped;
      erasing <= item.erase_mode;
      column  <= '0;
      row     <= '0;
      active  <= (w_clamped != '0) && (h_clamped != '0);
    end else if (push) begin
      if (is_last) begin
        active <= 1'b0;
        column <= '0;
        row    <= '0;
      end else if (col_inc >= {1'b0, span_w}) begin
        column <= '0;
        row    <= row_inc[SIDE_W-1:0];
      end else begin
        column <= col_inc[SIDE_W-1:0];
      end
    end
  end

endmodule

/* sv/ckblit_queue.sv */
// Short queue of classified pixel records between front and back.
module ckblit_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  ckblit_pkg::pixel_rec_t    push_rec,
  input  logic                      pop,
  output ckblit_pkg::pixel_rec_t    head,
  output ckblit_pkg::queue_status_t status
);
  import ckblit_pkg::*;

  pixel_rec_t             entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign status.full  = count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/ckblit_back.sv */
// Back part: address arithmetic in two stages and the result register.
module ckblit_back (
  input  logic                      clk,
  input  logic                      rst,
  input  ckblit_pkg::queue_status_t q_status,
  input  ckblit_pkg::pixel_rec_t    head,
  output logic                      pop,
  input  logic [11:0]               stride,
  output logic                      result_valid,
  input  logic                      result_stall,
  output ckblit_pkg::result_t       result
);
  import ckblit_pkg::*;

  // Stage A: pixel index y * stride + x
  logic        a_valid;
  logic [24:0] a_index;
  logic        a_we;
  logic [31:0] a_data;
  logic [2:0]  a_bytes;
  logic        a_last;

  logic        out_adv;
  logic        a_adv;
  logic        rec_valid;
  logic [23:0] row_base;
  logic [24:0] index_next;
  logic [26:0] addr_full;

  assign rec_valid = !q_status.empty;
  assign out_adv   = !result_valid || !result_stall;
  assign a_adv     = !a_valid || out_adv;
  assign pop       = rec_valid && a_adv;

  assign row_base   = head.y * stride;
  assign index_next = head.we ? ({1'b0, row_base} + 25'(head.x)) : 25'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_index <= index_next;
      a_we    <= head.we;
      a_data  <= head.data;
      a_bytes <= head.bytes;
      a_last  <= head.last;
    end
  end

  // Stage B: scale by bytes per pixel (1 to 4) with shifts and one add
  always_comb begin
    case (a_bytes)
      3'd1:    addr_full = 27'(a_index);
      3'd2:    addr_full = {1'b0, a_index, 1'b0};
      3'd3:    addr_full = 27'(a_index) + {1'b0, a_index, 1'b0};
      default: addr_full = {a_index, 2'b00};
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_adv) begin
      result_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && a_valid) begin
      result.write_enable <= a_we;
      result.byte_address <= addr_full[25:0];
      result.write_data   <= a_data;
      result.byte_count   <= a_bytes;
      result.last         <= a_last;
    end
  end

endmodule
